// ===== rtl/core/dbpq_pkg.sv =====
// Shared sizes, codes and types of the direct bucket priority queue.
package dbpq_pkg;

    localparam int NUM_BUCKETS = 256;
    localparam int NUM_ELEMS   = 1024;

    localparam int ELEM_W = $clog2(NUM_ELEMS);
    localparam int BKT_W  = $clog2(NUM_BUCKETS);
    localparam int LINK_W = $clog2(NUM_ELEMS + 1);
    localparam int CNT_W  = $clog2(NUM_ELEMS + 1);
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_ELEMS);

    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
    localparam logic [OP_W-1:0] OP_UPDATE  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_MIN = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_MAX = 3'd4;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [ST_W-1:0] ST_REJECT = 2'd2;

    // occupancy bitmap update request
    typedef struct packed {
        logic             set_en;
        logic             clr_en;
        logic [BKT_W-1:0] idx;
    } occ_upd_t;

    // bucket search result
    typedef struct packed {
        logic             found;
        logic [BKT_W-1:0] bucket;
    } scan_res_t;

endpackage

// ===== rtl/core/dbpq_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module dbpq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/dbpq_scan.sv =====
// Bucket occupancy bitmap with min/max priority encoders from the hints.
module dbpq_scan (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dbpq_pkg::occ_upd_t         upd,
    input  logic [dbpq_pkg::BKT_W-1:0] low_hint,
    input  logic [dbpq_pkg::BKT_W-1:0] high_hint,
    input  logic                       is_max,
    input  logic [dbpq_pkg::BKT_W-1:0] q_idx,
    output logic                       q_occ,
    output dbpq_pkg::scan_res_t        res
);

    logic [dbpq_pkg::NUM_BUCKETS-1:0] occ_reg;
    logic [dbpq_pkg::NUM_BUCKETS-1:0] occ_next;
    dbpq_pkg::scan_res_t              res_min;
    dbpq_pkg::scan_res_t              res_max;

    always_comb
    begin
        occ_next = occ_reg;
        if (upd.set_en)
        begin
            occ_next[upd.idx] = 1'b1;
        end
        if (upd.clr_en)
        begin
            occ_next[upd.idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    assign q_occ = occ_reg[q_idx];

    // lowest occupied bucket at or above the low hint
    always_comb
    begin
        res_min = '0;
        for (int i = dbpq_pkg::NUM_BUCKETS - 1; i >= 0; i--)
        begin
            if (occ_reg[i] && (dbpq_pkg::BKT_W'(i) >= low_hint))
            begin
                res_min.found  = 1'b1;
                res_min.bucket = dbpq_pkg::BKT_W'(i);
            end
        end
    end

    // highest occupied bucket at or below the high hint
    always_comb
    begin
        res_max = '0;
        for (int i = 0; i < dbpq_pkg::NUM_BUCKETS; i++)
        begin
            if (occ_reg[i] && (dbpq_pkg::BKT_W'(i) <= high_hint))
            begin
                res_max.found  = 1'b1;
                res_max.bucket = dbpq_pkg::BKT_W'(i);
            end
        end
    end

    assign res = is_max ? res_max : res_min;

endmodule

// ===== rtl/core/direct_bucket_priority_queue.sv =====
// Top level of the direct bucket priority queue: sequencer, link memories, result register.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  in       | input     | in_valid/in_ready  | op, elem, value
//  out      | output    | out_valid/out_ready| out_elem, out_value, status, queued_count
//  cfg      | input     | cfg_valid/cfg_ready| cfg_data (tie_order)
//
// One item at a time: a reject or empty pop goes DECIDE, RESP; remove and pop add UNLINK;
// insert adds APP_RD, APP1, APP2; update of a queued element adds UNLINK and the APP states.
// The result is registered on the move from RESP to IDLE, where the next accept can happen.
// Each link change is a read-modify-write through synchronous RAMs; an append writes the
// next-link RAM in both APP1 and APP2 because that RAM has one write port.
// After reset all NUM_ELEMS (1024) element mark RAM entries are swept to zero while in_ready is low.
// The output register parts the channels: a stalled result holds only the finishing step,
// and the next transfer is taken while the previous result waits.
module direct_bucket_priority_queue (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [dbpq_pkg::OP_W-1:0]   op,
    input  logic [dbpq_pkg::ELEM_W-1:0] elem,
    input  logic [dbpq_pkg::BKT_W-1:0]  value,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dbpq_pkg::ELEM_W-1:0] out_elem,
    output logic [dbpq_pkg::BKT_W-1:0]  out_value,
    output logic [dbpq_pkg::ST_W-1:0]   status,
    output logic [dbpq_pkg::CNT_W-1:0]  queued_count,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data
);

    localparam int EW = dbpq_pkg::ELEM_W;
    localparam int BW = dbpq_pkg::BKT_W;
    localparam int LW = dbpq_pkg::LINK_W;
    localparam int CW = dbpq_pkg::CNT_W;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_DECIDE = 8'b0000_0100,
        S_UNLINK = 8'b0000_1000,
        S_APP_RD = 8'b0001_0000,
        S_APP1   = 8'b0010_0000,
        S_APP2   = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // control registers
    logic [EW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [BW-1:0]  low_hint_reg, low_hint_next;
    logic [BW-1:0]  high_hint_reg, high_hint_next;
    logic           tie_reg;
    logic           out_valid_reg;

    // per-item working registers
    logic [dbpq_pkg::OP_W-1:0] op_reg;
    logic [EW-1:0]  elem_reg;
    logic [BW-1:0]  value_reg;
    logic           found_reg;
    logic [BW-1:0]  pop_bkt_reg;
    logic [EW-1:0]  e_reg, e_next;
    logic [BW-1:0]  b_reg, b_next;
    logic [EW-1:0]  res_elem_reg, res_elem_next;
    logic [BW-1:0]  res_value_reg, res_value_next;
    logic [dbpq_pkg::ST_W-1:0] res_st_reg, res_st_next;

    // output register
    logic [EW-1:0]  out_elem_reg;
    logic [BW-1:0]  out_value_reg;
    logic [dbpq_pkg::ST_W-1:0] status_reg;
    logic [CW-1:0]  queued_count_reg;

    // RAM ports
    logic           mark_we, mark_re, mark_wd, mark_rd;
    logic [EW-1:0]  mark_wa, mark_ra;
    logic           val_we, val_re;
    logic [EW-1:0]  val_wa, val_ra;
    logic [BW-1:0]  val_wd, val_rd;
    logic           prev_we, prev_re;
    logic [EW-1:0]  prev_wa, prev_ra;
    logic [LW-1:0]  prev_wd, prev_rd;
    logic           next_we, next_re;
    logic [EW-1:0]  next_wa, next_ra;
    logic [LW-1:0]  next_wd, next_rd;
    logic           head_we, head_re;
    logic [BW-1:0]  head_wa, head_ra;
    logic [EW-1:0]  head_wd, head_rd;
    logic           tail_we, tail_re;
    logic [BW-1:0]  tail_wa, tail_ra;
    logic [EW-1:0]  tail_wd, tail_rd;

    // bitmap
    dbpq_pkg::occ_upd_t  occ_upd;
    dbpq_pkg::scan_res_t scan_res;
    logic                q_occ;

    logic           in_xfer;
    logic           out_load;
    logic           e_ok, v_ok;
    logic           is_pop, is_max;
    logic [EW-1:0]  pop_x;
    logic           p_nil, n_nil;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid && in_ready;
    assign out_load  = (state_reg == S_RESP) && (!out_valid_reg || out_ready);

    assign e_ok   = (32'(elem_reg) < dbpq_pkg::NUM_ELEMS);
    assign v_ok   = (32'(value_reg) < dbpq_pkg::NUM_BUCKETS);
    assign is_pop = (op_reg == dbpq_pkg::OP_POP_MIN) || (op_reg == dbpq_pkg::OP_POP_MAX);
    assign is_max = (op == dbpq_pkg::OP_POP_MAX);
    assign pop_x  = tie_reg ? tail_rd : head_rd;
    assign p_nil  = (prev_rd == dbpq_pkg::NIL_LINK);
    assign n_nil  = (next_rd == dbpq_pkg::NIL_LINK);

    dbpq_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (occ_upd),
        .low_hint  (low_hint_reg),
        .high_hint (high_hint_reg),
        .is_max    (is_max),
        .q_idx     (value_reg),
        .q_occ     (q_occ),
        .res       (scan_res)
    );

    dbpq_ram #(.DEPTH(dbpq_pkg::NUM_ELEMS), .WIDTH(1)) u_mark_ram (
        .clk(clk), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd),
        .re(mark_re), .raddr(mark_ra), .rdata(mark_rd)
    );

    dbpq_ram #(.DEPTH(dbpq_pkg::NUM_ELEMS), .WIDTH(BW)) u_val_ram (
        .clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_wd),
        .re(val_re), .raddr(val_ra), .rdata(val_rd)
    );

    dbpq_ram #(.DEPTH(dbpq_pkg::NUM_ELEMS), .WIDTH(LW)) u_prev_ram (
        .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
        .re(prev_re), .raddr(prev_ra), .rdata(prev_rd)
    );

    dbpq_ram #(.DEPTH(dbpq_pkg::NUM_ELEMS), .WIDTH(LW)) u_next_ram (
        .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
        .re(next_re), .raddr(next_ra), .rdata(next_rd)
    );

    dbpq_ram #(.DEPTH(dbpq_pkg::NUM_BUCKETS), .WIDTH(EW)) u_head_ram (
        .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
        .re(head_re), .raddr(head_ra), .rdata(head_rd)
    );

    dbpq_ram #(.DEPTH(dbpq_pkg::NUM_BUCKETS), .WIDTH(EW)) u_tail_ram (
        .clk(clk), .we(tail_we), .waddr(tail_wa), .wdata(tail_wd),
        .re(tail_re), .raddr(tail_ra), .rdata(tail_rd)
    );

    // RAM access per state. Reads issued in one state are seen in the next;
    // read data registers hold while no new read is issued.
    always_comb
    begin
        mark_we = 1'b0; mark_wa = e_reg; mark_wd = 1'b0;
        mark_re = 1'b0; mark_ra = elem;
        val_we  = 1'b0; val_wa  = e_reg; val_wd  = b_reg;
        val_re  = 1'b0; val_ra  = elem;
        prev_we = 1'b0; prev_wa = e_reg; prev_wd = dbpq_pkg::NIL_LINK;
        prev_re = 1'b0; prev_ra = elem;
        next_we = 1'b0; next_wa = e_reg; next_wd = dbpq_pkg::NIL_LINK;
        next_re = 1'b0; next_ra = elem;
        head_we = 1'b0; head_wa = b_reg; head_wd = e_reg;
        head_re = 1'b0; head_ra = scan_res.bucket;
        tail_we = 1'b0; tail_wa = b_reg; tail_wd = e_reg;
        tail_re = 1'b0; tail_ra = scan_res.bucket;
        occ_upd = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mark_we = 1'b1;
                mark_wa = clr_cnt_reg;
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    mark_re = 1'b1;
                    val_re  = 1'b1;
                    prev_re = 1'b1;
                    next_re = 1'b1;
                    head_re = 1'b1;
                    tail_re = 1'b1;
                end
            end
            S_DECIDE:
            begin
                // pop: fetch the links of the chosen element
                if (is_pop)
                begin
                    prev_re = 1'b1;
                    prev_ra = pop_x;
                    next_re = 1'b1;
                    next_ra = pop_x;
                end
            end
            S_UNLINK:
            begin
                mark_we = 1'b1;
                if (p_nil)
                begin
                    head_we = !n_nil;
                    head_wd = next_rd[EW-1:0];
                end
                else
                begin
                    next_we = 1'b1;
                    next_wa = prev_rd[EW-1:0];
                    next_wd = next_rd;
                end
                if (n_nil)
                begin
                    tail_we = !p_nil;
                    tail_wd = prev_rd[EW-1:0];
                end
                else
                begin
                    prev_we = 1'b1;
                    prev_wa = next_rd[EW-1:0];
                    prev_wd = prev_rd;
                end
                // last element of its bucket
                occ_upd.clr_en = p_nil && n_nil;
                occ_upd.idx    = b_reg;
            end
            S_APP_RD:
            begin
                tail_re = 1'b1;
                tail_ra = value_reg;
            end
            S_APP1:
            begin
                mark_we = 1'b1;
                mark_wd = 1'b1;
                val_we  = 1'b1;
                val_wd  = value_reg;
                prev_we = 1'b1;
                prev_wd = q_occ ? LW'(tail_rd) : dbpq_pkg::NIL_LINK;
                tail_we = 1'b1;
                tail_wa = value_reg;
                if (q_occ)
                begin
                    next_we = 1'b1;
                    next_wa = tail_rd;
                    next_wd = LW'(e_reg);
                end
                else
                begin
                    head_we = 1'b1;
                    head_wa = value_reg;
                end
                occ_upd.set_en = 1'b1;
                occ_upd.idx    = value_reg;
            end
            S_APP2:
            begin
                next_we = 1'b1;
            end
            S_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        count_next     = count_reg;
        low_hint_next  = low_hint_reg;
        high_hint_next = high_hint_reg;
        e_next         = e_reg;
        b_next         = b_reg;
        res_elem_next  = res_elem_reg;
        res_value_next = res_value_reg;
        res_st_next    = res_st_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + EW'(1);
                if (clr_cnt_reg == EW'(dbpq_pkg::NUM_ELEMS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                res_elem_next  = '0;
                res_value_next = '0;
                res_st_next    = dbpq_pkg::ST_OK;
                e_next         = elem_reg;
                b_next         = val_rd;
                state_next     = S_RESP;
                case (op_reg)
                    dbpq_pkg::OP_INSERT:
                    begin
                        if (!e_ok || !v_ok || mark_rd)
                        begin
                            res_st_next = dbpq_pkg::ST_REJECT;
                        end
                        else
                        begin
                            state_next = S_APP_RD;
                        end
                    end
                    dbpq_pkg::OP_REMOVE:
                    begin
                        if (!e_ok || !mark_rd)
                        begin
                            res_st_next = dbpq_pkg::ST_REJECT;
                        end
                        else
                        begin
                            state_next = S_UNLINK;
                        end
                    end
                    dbpq_pkg::OP_UPDATE:
                    begin
                        if (!e_ok || !v_ok)
                        begin
                            res_st_next = dbpq_pkg::ST_REJECT;
                        end
                        else
                        begin
                            state_next = mark_rd ? S_UNLINK : S_APP_RD;
                        end
                    end
                    dbpq_pkg::OP_POP_MIN, dbpq_pkg::OP_POP_MAX:
                    begin
                        if ((count_reg == '0) || !found_reg)
                        begin
                            res_st_next = dbpq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            e_next         = pop_x;
                            b_next         = pop_bkt_reg;
                            res_elem_next  = pop_x;
                            res_value_next = pop_bkt_reg;
                            state_next     = S_UNLINK;
                            if (op_reg == dbpq_pkg::OP_POP_MAX)
                            begin
                                high_hint_next = pop_bkt_reg;
                            end
                            else
                            begin
                                low_hint_next = pop_bkt_reg;
                            end
                        end
                    end
                    default:
                    begin
                        res_st_next = dbpq_pkg::ST_REJECT;
                    end
                endcase
            end
            S_UNLINK:
            begin
                count_next = count_reg - CW'(1);
                state_next = (op_reg == dbpq_pkg::OP_UPDATE) ? S_APP_RD : S_RESP;
            end
            S_APP_RD:
            begin
                state_next = S_APP1;
            end
            S_APP1:
            begin
                state_next = S_APP2;
            end
            S_APP2:
            begin
                count_next = count_reg + CW'(1);
                if (value_reg < low_hint_reg)
                begin
                    low_hint_next = value_reg;
                end
                if (value_reg > high_hint_reg)
                begin
                    high_hint_next = value_reg;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            count_reg     <= '0;
            low_hint_reg  <= BW'(dbpq_pkg::NUM_BUCKETS - 1);
            high_hint_reg <= '0;
            tie_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            count_reg     <= count_next;
            low_hint_reg  <= low_hint_next;
            high_hint_reg <= high_hint_next;
            if (cfg_valid && cfg_ready)
            begin
                tie_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg      <= op;
            elem_reg    <= elem;
            value_reg   <= value;
            found_reg   <= scan_res.found;
            pop_bkt_reg <= scan_res.bucket;
        end
        e_reg         <= e_next;
        b_reg         <= b_next;
        res_elem_reg  <= res_elem_next;
        res_value_reg <= res_value_next;
        res_st_reg    <= res_st_next;
        if (out_load)
        begin
            out_elem_reg     <= res_elem_reg;
            out_value_reg    <= res_value_reg;
            status_reg       <= res_st_reg;
            queued_count_reg <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_elem     = out_elem_reg;
    assign out_value    = out_value_reg;
    assign status       = status_reg;
    assign queued_count = queued_count_reg;

endmodule

// ===== rtl/core/dbpq_checker.sv =====
// Port-level assertions for the direct bucket priority queue, bound to the top level.
module dbpq_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [dbpq_pkg::ELEM_W-1:0] out_elem,
    input logic [dbpq_pkg::BKT_W-1:0]  out_value,
    input logic [dbpq_pkg::ST_W-1:0]   status,
    input logic [dbpq_pkg::CNT_W-1:0]  queued_count
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_elem) && $stable(status)
            && $stable(queued_count))
        else $error("result changed while stalled");

    // an empty pop reports an empty queue
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == dbpq_pkg::ST_EMPTY) |-> (queued_count == '0))
        else $error("empty status with queued elements");

    // a failed request or empty pop carries no element
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != dbpq_pkg::ST_OK) |-> (out_elem == '0) && (out_value == '0))
        else $error("failed request carries an element");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(queued_count) <= dbpq_pkg::NUM_ELEMS))
        else $error("queued count out of range");

endmodule

bind direct_bucket_priority_queue dbpq_checker u_dbpq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_elem     (out_elem),
    .out_value    (out_value),
    .status       (status),
    .queued_count (queued_count)
);
